>>> rtl/dtmp_pkg.sv
// Shared types and constants for the device-tree memory size patcher.
// Used by the walker, the top level and the testbench.
package dtmp_pkg;

	localparam int BLOB_BYTES_DEF = 16384;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_RUN   = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_HEADER    = 3'd1;
	localparam logic [2:0] ST_MALFORMED = 3'd2;
	localparam logic [2:0] ST_REGLEN    = 3'd3;
	localparam logic [2:0] ST_NOTFOUND  = 3'd4;

	localparam logic [0:0] CFG_MEM_BASE = 1'b0;
	localparam logic [0:0] CFG_MEM_SIZE = 1'b1;

	localparam logic [31:0] DTB_SIGNATURE  = 32'hd00dfeed;
	localparam logic [31:0] TOK_BEGIN_NODE = 32'd1;
	localparam logic [31:0] TOK_END_NODE   = 32'd2;
	localparam logic [31:0] TOK_PROP       = 32'd3;
	localparam logic [31:0] TOK_NOP        = 32'd4;
	localparam logic [31:0] TOK_END        = 32'd9;

	localparam int HDR_MIN_LEN = 40;
	localparam int REG_LEN     = 16;

	localparam logic [7:0] MEM_PREFIX [7] = '{8'h6d, 8'h65, 8'h6d, 8'h6f, 8'h72, 8'h79, 8'h40};
	localparam logic [7:0] REG_NAME [4]   = '{8'h72, 8'h65, 8'h67, 8'h00};

	typedef struct packed {
		logic [1:0]  opcode;
		logic [13:0] byte_address;
		logic [7:0]  write_byte;
		logic [14:0] blob_length;
	} item_t;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  read_byte;
		logic [2:0]  status;
		logic [13:0] patch_offset;
	} res_t;

endpackage

>>> rtl/dtmp_if.sv
// Valid/ready channel interfaces for items, results and configuration writes.
// No dependencies.
interface dtmp_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [13:0] byte_address;
	logic [7:0]  write_byte;
	logic [14:0] blob_length;
	modport source (output valid, opcode, byte_address, write_byte, blob_length, input ready);
	modport sink (input valid, opcode, byte_address, write_byte, blob_length, output ready);
endinterface

interface dtmp_result_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [7:0]  read_byte;
	logic [2:0]  status;
	logic [13:0] patch_offset;
	modport source (output valid, result_kind, read_byte, status, patch_offset, input ready);
	modport sink (input valid, result_kind, read_byte, status, patch_offset, output ready);
endinterface

interface dtmp_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [63:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/dtmp_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module dtmp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

>>> rtl/dtmp_walker.sv
// Sequencer that serves byte loads and reads and walks the stored blob.
// Depends on dtmp_pkg; drives the byte store port.
module dtmp_walker #(
	parameter int BLOB_BYTES = dtmp_pkg::BLOB_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  dtmp_pkg::item_t               item,
	output logic                          in_ready,
	input  logic                          res_free,
	input  logic [63:0]                   mem_base,
	input  logic [63:0]                   mem_size,
	output logic                          res_valid,
	output dtmp_pkg::res_t                res,
	output logic                          ram_we,
	output logic [$clog2(BLOB_BYTES)-1:0] ram_addr,
	output logic [7:0]                    ram_wdata,
	input  logic [7:0]                    ram_rdata
);
	import dtmp_pkg::*;

	localparam int ADDR_W = $clog2(BLOB_BYTES);
	localparam int LEN_W  = $clog2(BLOB_BYTES + 1);
	localparam int P_W    = LEN_W + 1;
	localparam int DW     = P_W + 1;

	typedef enum logic [4:0] {
		S_IDLE, S_RD, S_HDR, S_FET_ISS, S_FET_CAP, S_H_MAGIC, S_H_TOTAL, S_H_STRU,
		S_H_STR, S_H_LEN, S_TOK, S_TOK_DEC, S_NAME_ISS, S_NAME_CAP, S_PROP_LEN,
		S_PROP_OFF, S_REG_ISS, S_REG_CAP, S_WR
	} state_t;

	state_t                 state_q, ret_q;
	logic                   res_valid_q, rd_ok_q, in_mem_q, match_q;
	res_t                   res_q;
	logic [LEN_W-1:0]       len_q, end_q, n_q, s_q;
	logic [P_W-1:0]         p_q, fa_q;
	logic [31:0]            word_q, total_q, stru_q, str_q, plen_q;
	logic [3:0]             cnt_q;
	logic [1:0]             k_q;
	logic signed [DW-1:0]   depth_q;
	logic                   fire, in_range;
	logic [LEN_W-1:0]       len_c;
	logic [P_W-1:0]         p4, p8, pad;
	logic [127:0]           patch_data;

	assign in_ready   = (state_q == S_IDLE) && !res_valid_q && res_free;
	assign fire       = in_valid && in_ready;
	assign in_range   = 32'(item.byte_address) < 32'(BLOB_BYTES);
	assign len_c      = (32'(item.blob_length) > 32'(BLOB_BYTES)) ? LEN_W'(BLOB_BYTES)
	                                                              : LEN_W'(item.blob_length);
	assign p4         = p_q + P_W'(4);
	assign p8         = p_q + P_W'(8);
	assign pad        = P_W'((33'(plen_q) + 33'd3) & ~33'd3);
	assign patch_data = {mem_base, mem_size};
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = ADDR_W'(fa_q + P_W'(cnt_q[1:0]));
		ram_wdata = item.write_byte;
		unique case (state_q)
			S_IDLE: begin
				ram_we   = fire && (item.opcode == OP_WRITE) && in_range;
				ram_addr = ADDR_W'(item.byte_address);
			end
			S_NAME_ISS: ram_addr = ADDR_W'(p_q + P_W'(n_q));
			S_REG_ISS:  ram_addr = ADDR_W'(s_q + LEN_W'(k_q));
			S_WR: begin
				ram_we    = 1'b1;
				ram_addr  = ADDR_W'(p_q + P_W'(cnt_q));
				ram_wdata = patch_data[8 * (4'd15 - cnt_q) +: 8];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			res_valid_q <= 1'b0;
			res_q       <= '0;
			in_mem_q    <= 1'b0;
			cnt_q       <= '0;
		end else begin
			res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (fire) begin
						rd_ok_q  <= in_range;
						len_q    <= len_c;
						in_mem_q <= 1'b0;
						depth_q  <= '0;
						cnt_q    <= '0;
						if (item.opcode == OP_READ) begin
							state_q <= S_RD;
						end else if (item.opcode == OP_RUN) begin
							state_q <= S_HDR;
						end
					end
				end
				S_RD: begin
					res_valid_q <= 1'b1;
					res_q       <= '{1'b0, rd_ok_q ? ram_rdata : 8'd0, ST_OK, 14'd0};
					state_q     <= S_IDLE;
				end
				S_HDR: begin
					if (32'(len_q) < 32'(HDR_MIN_LEN)) begin
						res_valid_q <= 1'b1;
						res_q       <= '{1'b1, 8'd0, ST_HEADER, 14'd0};
						state_q     <= S_IDLE;
					end else begin
						fa_q    <= '0;
						ret_q   <= S_H_MAGIC;
						state_q <= S_FET_ISS;
					end
				end
				S_FET_ISS: state_q <= S_FET_CAP;
				S_FET_CAP: begin
					word_q <= {word_q[23:0], ram_rdata};
					if (cnt_q[1:0] == 2'd3) begin
						cnt_q   <= '0;
						state_q <= ret_q;
					end else begin
						cnt_q   <= cnt_q + 4'd1;
						state_q <= S_FET_ISS;
					end
				end
				S_H_MAGIC: begin
					if (word_q != DTB_SIGNATURE) begin
						res_valid_q <= 1'b1;
						res_q       <= '{1'b1, 8'd0, ST_HEADER, 14'd0};
						state_q     <= S_IDLE;
					end else begin
						fa_q    <= P_W'(4);
						ret_q   <= S_H_TOTAL;
						state_q <= S_FET_ISS;
					end
				end
				S_H_TOTAL: begin
					total_q <= word_q;
					fa_q    <= P_W'(8);
					ret_q   <= S_H_STRU;
					state_q <= S_FET_ISS;
				end
				S_H_STRU: begin
					stru_q  <= word_q;
					fa_q    <= P_W'(12);
					ret_q   <= S_H_STR;
					state_q <= S_FET_ISS;
				end
				S_H_STR: begin
					str_q   <= word_q;
					fa_q    <= P_W'(36);
					ret_q   <= S_H_LEN;
					state_q <= S_FET_ISS;
				end
				S_H_LEN: begin
					if ((33'(total_q) > 33'(len_q))
					    || (33'(stru_q) + 33'(word_q) > 33'(total_q))
					    || (str_q > total_q)) begin
						res_valid_q <= 1'b1;
						res_q       <= '{1'b1, 8'd0, ST_HEADER, 14'd0};
						state_q     <= S_IDLE;
					end else begin
						p_q     <= P_W'(stru_q);
						end_q   <= LEN_W'(stru_q + word_q);
						state_q <= S_TOK;
					end
				end
				S_TOK: begin
					if (33'(p_q) + 33'd4 > 33'(end_q)) begin
						res_valid_q <= 1'b1;
						res_q       <= '{1'b1, 8'd0, ST_NOTFOUND, 14'd0};
						state_q     <= S_IDLE;
					end else begin
						fa_q    <= p_q;
						ret_q   <= S_TOK_DEC;
						state_q <= S_FET_ISS;
					end
				end
				S_TOK_DEC: begin
					p_q <= p4;
					case (word_q)
						TOK_BEGIN_NODE: begin
							n_q     <= '0;
							match_q <= 1'b1;
							state_q <= S_NAME_ISS;
						end
						TOK_END_NODE: begin
							if (in_mem_q && depth_q == DW'(2)) begin
								in_mem_q <= 1'b0;
							end
							depth_q <= depth_q - DW'(1);
							state_q <= S_TOK;
						end
						TOK_PROP: begin
							if (33'(p4) + 33'd8 > 33'(end_q)) begin
								res_valid_q <= 1'b1;
								res_q       <= '{1'b1, 8'd0, ST_MALFORMED, 14'd0};
								state_q     <= S_IDLE;
							end else begin
								fa_q    <= p4;
								ret_q   <= S_PROP_LEN;
								state_q <= S_FET_ISS;
							end
						end
						TOK_NOP: state_q <= S_TOK;
						TOK_END: begin
							res_valid_q <= 1'b1;
							res_q       <= '{1'b1, 8'd0, ST_NOTFOUND, 14'd0};
							state_q     <= S_IDLE;
						end
						default: begin
							res_valid_q <= 1'b1;
							res_q       <= '{1'b1, 8'd0, ST_MALFORMED, 14'd0};
							state_q     <= S_IDLE;
						end
					endcase
				end
				S_NAME_ISS: begin
					if (33'(p_q) + 33'(n_q) >= 33'(len_q)) begin
						res_valid_q <= 1'b1;
						res_q       <= '{1'b1, 8'd0, ST_MALFORMED, 14'd0};
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_NAME_CAP;
					end
				end
				S_NAME_CAP: begin
					if (ram_rdata == 8'd0) begin
						p_q     <= p_q + P_W'((33'(n_q) + 33'd4) & ~33'd3);
						depth_q <= depth_q + DW'(1);
						if (!in_mem_q && depth_q == DW'(1) && match_q
						    && n_q >= LEN_W'(7)) begin
							in_mem_q <= 1'b1;
						end
						state_q <= S_TOK;
					end else begin
						if (n_q < LEN_W'(7) && ram_rdata != MEM_PREFIX[n_q[2:0]]) begin
							match_q <= 1'b0;
						end
						n_q     <= n_q + LEN_W'(1);
						state_q <= S_NAME_ISS;
					end
				end
				S_PROP_LEN: begin
					plen_q  <= word_q;
					fa_q    <= p4;
					ret_q   <= S_PROP_OFF;
					state_q <= S_FET_ISS;
				end
				S_PROP_OFF: begin
					if (33'(p8) + 33'(plen_q) > 33'(end_q)) begin
						res_valid_q <= 1'b1;
						res_q       <= '{1'b1, 8'd0, ST_MALFORMED, 14'd0};
						state_q     <= S_IDLE;
					end else if (in_mem_q && (33'(str_q) + 33'(word_q) < 33'(total_q))) begin
						p_q     <= p8;
						s_q     <= LEN_W'(str_q + word_q);
						k_q     <= '0;
						state_q <= S_REG_ISS;
					end else begin
						p_q     <= p8 + pad;
						state_q <= S_TOK;
					end
				end
				S_REG_ISS: begin
					if (33'(s_q) + 33'(k_q) >= 33'(len_q)) begin
						res_valid_q <= 1'b1;
						res_q       <= '{1'b1, 8'd0, ST_MALFORMED, 14'd0};
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_REG_CAP;
					end
				end
				S_REG_CAP: begin
					if (ram_rdata != REG_NAME[k_q]) begin
						p_q     <= p_q + pad;
						state_q <= S_TOK;
					end else if (k_q == 2'd3) begin
						if (plen_q != 32'(REG_LEN)) begin
							res_valid_q <= 1'b1;
							res_q       <= '{1'b1, 8'd0, ST_REGLEN, 14'd0};
							state_q     <= S_IDLE;
						end else begin
							cnt_q   <= '0;
							state_q <= S_WR;
						end
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= S_REG_ISS;
					end
				end
				S_WR: begin
					if (cnt_q == 4'd15) begin
						cnt_q       <= '0;
						res_valid_q <= 1'b1;
						res_q       <= '{1'b1, 8'd0, ST_OK, 14'(p_q)};
						state_q     <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_write_only_load_or_patch: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_IDLE || state_q == S_WR))
		else $error("byte store written outside a load or a patch");
	a_no_accept_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !fire)
		else $error("item accepted while a result is being handed over");
	a_offset_only_on_patch: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.status != ST_OK) |-> (res_q.patch_offset == 14'd0))
		else $error("patch offset reported without a patch");
	a_patch_ends_write: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.result_kind && res_q.status == ST_OK)
		|-> ($past(state_q) == S_WR))
		else $error("patched status without the value being rewritten");
`endif

endmodule

>>> rtl/device_tree_memory_size_patcher.sv
// Device-tree memory size patcher top level: channels, registers, byte store.
// A write item is stored as it is accepted; a read result passes the store read register,
// the walker result register and the output register. A run reads each 32-bit word and
// each name bytewise over the single store port, then rewrites the 16-byte reg value.
// One item is in work at a time; the result register frees the input side.
// Reset clears mem_base, mem_size and control state; the store is undefined until written.
module device_tree_memory_size_patcher #(
	parameter int BLOB_BYTES = dtmp_pkg::BLOB_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	dtmp_item_if.sink     items,
	dtmp_result_if.source results,
	dtmp_cfg_if.sink      cfg
);
	import dtmp_pkg::*;

	localparam int ADDR_W = $clog2(BLOB_BYTES);

	logic [63:0]       mem_base_q, mem_size_q;
	logic              out_valid_q;
	res_t              out_q;
	item_t             item;
	res_t              wres;
	logic              wres_valid, ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [7:0]        ram_wdata, ram_rdata;

	assign item      = '{items.opcode, items.byte_address, items.write_byte, items.blob_length};
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_base_q  <= '0;
			mem_size_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					CFG_MEM_BASE: mem_base_q <= cfg.data;
					CFG_MEM_SIZE: mem_size_q <= cfg.data;
					default: ;
				endcase
			end
			if (wres_valid) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wres_valid) begin
			out_q <= wres;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.result_kind  = out_q.result_kind;
	assign results.read_byte    = out_q.read_byte;
	assign results.status       = out_q.status;
	assign results.patch_offset = out_q.patch_offset;

	dtmp_walker #(.BLOB_BYTES(BLOB_BYTES)) u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.item      (item),
		.in_ready  (items.ready),
		.res_free  (!out_valid_q || results.ready),
		.mem_base  (mem_base_q),
		.mem_size  (mem_size_q),
		.res_valid (wres_valid),
		.res       (wres),
		.ram_we    (ram_we),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata),
		.ram_rdata (ram_rdata)
	);

	dtmp_ram #(.WIDTH(8), .DEPTH(BLOB_BYTES)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

endmodule

>>> test/device_tree_memory_size_patcher_test.sv
// Self-checking testbench for the device-tree memory size patcher: loads generated blobs,
// corrupts and truncates them, runs the walker and checks every result beat in order.
// Depends on dtmp_pkg, the channel interfaces and the top level.
`timescale 1ns / 1ps

module device_tree_memory_size_patcher_test;
	import dtmp_pkg::*;

	localparam logic [1:0] OP_IGNORED = 2'd3;
	localparam int STORE_BYTES = BLOB_BYTES_DEF;
	localparam int IDLE_LIMIT = 20000;

	logic clk;
	logic arst_n;

	dtmp_item_if   items_ch ();
	dtmp_result_if results_ch ();
	dtmp_cfg_if    cfg_ch ();

	device_tree_memory_size_patcher dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_ch),
		.results(results_ch),
		.cfg(cfg_ch)
	);

	logic [7:0]  blob_mirror [STORE_BYTES];
	bit          byte_known [STORE_BYTES];
	logic [63:0] base_reg;
	logic [63:0] size_reg;
	bit          stray_read;
	res_t        pending_results [$];
	logic [7:0]  struct_bytes [$];
	logic [7:0]  blob_image [$];
	longint unsigned last_patch_off;
	logic [2:0]  last_status;
	bit          no_idle;
	int          item_count, run_count, patched_count, read_count, cfg_count, mismatches;
	int          stall_left, idle_cycles;

	always #4 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] peek(longint unsigned a);
		if (!byte_known[a]) stray_read = 1;
		return blob_mirror[a];
	endfunction

	function automatic longint unsigned peek32(longint unsigned a);
		return 64'({peek(a), peek(a + 1), peek(a + 2), peek(a + 3)});
	endfunction

	// Walks the mirrored store; with commit clear it only probes which bytes a run touches.
	function automatic logic [2:0] walk_tree(longint unsigned len, bit commit,
			output longint unsigned off);
		longint unsigned total, ostr, ostru, lstru, p, e, tok, n, plen, noff, s;
		int depth, mem_depth;
		bit in_mem, match, is_reg;
		logic [7:0] c;
		off = 0;
		depth = 0;
		mem_depth = -1;
		in_mem = 0;
		if (len > STORE_BYTES) len = STORE_BYTES;
		if (len < HDR_MIN_LEN) return ST_HEADER;
		if (peek32(0) != 64'(DTB_SIGNATURE)) return ST_HEADER;
		total = peek32(4);
		ostru = peek32(8);
		ostr = peek32(12);
		lstru = peek32(36);
		if (total > len || ostru + lstru > total || ostr > total) return ST_HEADER;
		p = ostru;
		e = ostru + lstru;
		while (p + 4 <= e) begin
			tok = peek32(p);
			p += 4;
			if (tok == 64'(TOK_BEGIN_NODE)) begin
				n = 0;
				match = 1;
				forever begin
					if (p + n >= len) return ST_MALFORMED;
					c = peek(p + n);
					if (c == 0) break;
					if (n < 7 && c != MEM_PREFIX[n]) match = 0;
					n++;
				end
				if (n < 7) match = 0;
				p += (n + 4) & ~64'd3;
				depth++;
				if (!in_mem && depth == 2 && match) begin
					in_mem = 1;
					mem_depth = depth;
				end
			end else if (tok == 64'(TOK_END_NODE)) begin
				if (in_mem && depth == mem_depth) in_mem = 0;
				depth--;
			end else if (tok == 64'(TOK_PROP)) begin
				if (p + 8 > e) return ST_MALFORMED;
				plen = peek32(p);
				noff = peek32(p + 4);
				p += 8;
				if (p + plen > e) return ST_MALFORMED;
				if (in_mem && ostr + noff < total) begin
					s = ostr + noff;
					is_reg = 1;
					for (int k = 0; k < 4; k++) begin
						if (s + k >= len) return ST_MALFORMED;
						c = peek(s + k);
						if (c != REG_NAME[k]) begin
							is_reg = 0;
							break;
						end
					end
					if (is_reg) begin
						if (plen != REG_LEN) return ST_REGLEN;
						if (commit) begin
							for (int i = 0; i < 8; i++) begin
								blob_mirror[p + i] = base_reg[63 - 8 * i -: 8];
								blob_mirror[p + 8 + i] = size_reg[63 - 8 * i -: 8];
								byte_known[p + i] = 1;
								byte_known[p + 8 + i] = 1;
							end
						end
						off = p;
						return ST_OK;
					end
				end
				p += (plen + 3) & ~64'd3;
			end else if (tok == 64'(TOK_NOP)) begin
			end else if (tok == 64'(TOK_END)) begin
				break;
			end else begin
				return ST_MALFORMED;
			end
		end
		return ST_NOTFOUND;
	endfunction

	function automatic bit run_is_safe(longint unsigned len);
		longint unsigned off;
		stray_read = 0;
		void'(walk_tree(len, 0, off));
		return !stray_read;
	endfunction

	task automatic send_item(input logic [1:0] op, input logic [13:0] addr,
			input logic [7:0] wbyte, input logic [14:0] blen);
		int gap;
		res_t r;
		longint unsigned off;
		gap = pick_gap();
		r = '0;
		case (op)
			OP_WRITE: begin
				blob_mirror[addr] = wbyte;
				byte_known[addr] = 1;
			end
			OP_READ: begin
				r.read_byte = blob_mirror[addr];
				pending_results.push_back(r);
				read_count++;
			end
			OP_RUN: begin
				r.result_kind = 1;
				r.status = walk_tree(64'(blen), 1, off);
				r.patch_offset = off[13:0];
				last_status = r.status;
				last_patch_off = off;
				pending_results.push_back(r);
				run_count++;
				if (r.status == ST_OK) patched_count++;
			end
			default: ;
		endcase
		if (op != OP_IGNORED) item_count++;
		if (gap > 0) begin
			items_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items_ch.valid <= 1'b1;
		items_ch.opcode <= op;
		items_ch.byte_address <= addr;
		items_ch.write_byte <= wbyte;
		items_ch.blob_length <= blen;
		do @(posedge clk); while (!items_ch.ready);
	endtask

	task automatic read_known();
		logic [13:0] a;
		a = 14'($urandom);
		for (int t = 0; t < 64 && !byte_known[a]; t++) a = 14'($urandom);
		if (!byte_known[a]) a = 14'd0;
		send_item(OP_READ, a, 8'($urandom), 15'($urandom));
	endtask

	task automatic run_walk(input longint unsigned preferred);
		logic [14:0] len;
		len = 15'($urandom);
		for (int t = 0; t < 8 && !run_is_safe(64'(len)); t++) len = 15'($urandom);
		if (!run_is_safe(64'(len))) len = 15'(preferred);
		send_item(OP_RUN, 14'($urandom), 8'($urandom), len);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [63:0] value);
		items_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == CFG_MEM_BASE) base_reg = value;
		else size_reg = value;
		cfg_count++;
	endtask

	task automatic put32(input logic [31:0] v);
		for (int i = 3; i >= 0; i--) struct_bytes.push_back(v[8 * i +: 8]);
	endtask

	task automatic pad4();
		while (struct_bytes.size() % 4 != 0) struct_bytes.push_back(8'h00);
	endtask

	task automatic put_node(input string nm);
		put32(TOK_BEGIN_NODE);
		for (int i = 0; i < nm.len(); i++) struct_bytes.push_back(nm[i]);
		struct_bytes.push_back(8'h00);
		pad4();
	endtask

	task automatic put_prop(input logic [31:0] name_off, input int len);
		put32(TOK_PROP);
		put32(len);
		put32(name_off);
		repeat (len) struct_bytes.push_back(8'($urandom));
		pad4();
	endtask

	// Strings: "reg" at 0, "device_type" at 4, "compatible" at 16, "regulator" at 27.
	task automatic build_blob();
		string names;
		int variant, decoy, str_off, total;
		int reg_lens [4] = '{8, 12, 24, 0};
		names = "reg device_type compatible regulator ";
		struct_bytes.delete();
		blob_image.delete();
		put_node("");
		if ($urandom_range(0, 1)) put_prop(16, $urandom_range(4, 12));
		if ($urandom_range(0, 1)) put32(TOK_NOP);
		put_node("cpus");
		put_node("cpu@0");
		put_prop(0, 16);
		put32(TOK_END_NODE);
		put32(TOK_END_NODE);
		decoy = $urandom_range(0, 3);
		if (decoy == 1) put_node("memory");
		if (decoy == 2) put_node("memorz@0");
		if (decoy == 3) begin
			put_node("soc");
			put_node("memory@1");
		end
		if (decoy != 0) put_prop(0, 16);
		if (decoy == 3) put32(TOK_END_NODE);
		if (decoy != 0) put32(TOK_END_NODE);
		variant = $urandom_range(0, 9);
		put_node($sformatf("memory@%0h", $urandom_range(0, 65535)));
		put_prop(4, 7);
		if ($urandom_range(0, 3) == 0) put32(TOK_NOP);
		case (variant)
			6: put_prop(0, reg_lens[$urandom_range(0, 3)]);
			7: begin
				put_prop(27, 8);
				put32(TOK_END_NODE);
				put_node("memory@2");
				put_prop(0, 16);
			end
			8: put_prop(32'hffff0000, 16);
			9: begin
				put_node("bank@0");
				put_prop(0, 16);
				put32(TOK_END_NODE);
			end
			default: begin
				if ($urandom_range(0, 1)) put_prop(27, 4);
				put_prop(0, 16);
			end
		endcase
		put32(TOK_END_NODE);
		put32(TOK_END_NODE);
		if ($urandom_range(0, 7) != 0) put32(TOK_END);
		str_off = 40 + struct_bytes.size();
		total = str_off + names.len();
		for (int w = 0; w < 10; w++) begin
			logic [31:0] v;
			case (w)
				0: v = DTB_SIGNATURE;
				1: v = total;
				2: v = 40;
				3: v = str_off;
				4: v = 40;
				5: v = 17;
				6: v = 16;
				8: v = names.len();
				9: v = struct_bytes.size();
				default: v = 0;
			endcase
			for (int i = 3; i >= 0; i--) blob_image.push_back(v[8 * i +: 8]);
		end
		foreach (struct_bytes[i]) blob_image.push_back(struct_bytes[i]);
		for (int i = 0; i < names.len(); i++)
			blob_image.push_back(names[i] == " " ? 8'h00 : names[i]);
	endtask

	task automatic test_directed();
		send_item(OP_RUN, 14'd0, 8'd0, 15'd0);
		send_item(OP_WRITE, 14'd0, 8'hd0, 15'h7fff);
		send_item(OP_WRITE, 14'd1, 8'h0d, 15'd0);
		send_item(OP_WRITE, 14'd2, 8'hfe, 15'd0);
		send_item(OP_WRITE, 14'd3, 8'h00, 15'd0);
		send_item(OP_WRITE, 14'h3fff, 8'hff, 15'd0);
		send_item(OP_READ, 14'h3fff, 8'd0, 15'd0);
		send_item(OP_READ, 14'd0, 8'hff, 15'h7fff);
		send_item(OP_RUN, 14'h3fff, 8'hff, 15'h7fff);
		send_item(OP_RUN, 14'd0, 8'd0, 15'd16384);
		send_item(OP_RUN, 14'd0, 8'd0, 15'd39);
		send_item(OP_IGNORED, 14'h3fff, 8'hff, 15'h7fff);
		send_item(OP_WRITE, 14'h3fff, 8'h00, 15'd0);
		send_item(OP_READ, 14'h3fff, 8'd0, 15'd0);
		send_item(OP_READ, 14'd3, 8'd0, 15'd0);
	endtask

	task automatic test_blob_walks(input int runs);
		int pos, action;
		logic [7:0] saved;
		build_blob();
		foreach (blob_image[i]) send_item(OP_WRITE, 14'(i), blob_image[i], 15'($urandom));
		for (int r = 0; r < runs; r++) begin
			action = $urandom_range(0, 99);
			if (action < 40) begin
				send_item(OP_RUN, 14'($urandom), 8'($urandom),
					15'(blob_image.size() + ($urandom_range(0, 1) ? 0 : $urandom_range(0, 64))));
			end else if (action < 75) begin
				pos = $urandom_range(0, 1) ? $urandom_range(0, 39) :
					$urandom_range(0, blob_image.size() - 1);
				saved = blob_mirror[pos];
				send_item(OP_WRITE, 14'(pos), 8'($urandom_range(0, 1) ? $urandom :
					$urandom_range(0, 9)), 15'($urandom));
				run_walk(64'(blob_image.size()));
				send_item(OP_WRITE, 14'(pos), saved, 15'($urandom));
			end else if (action < 90) begin
				run_walk(64'(blob_image.size()));
			end else begin
				repeat ($urandom_range(1, 4)) read_known();
			end
			if (last_status == ST_OK && $urandom_range(0, 2) == 0)
				for (int i = 0; i < 16; i += $urandom_range(1, 5))
					send_item(OP_READ, 14'(last_patch_off + 64'(i)), 8'($urandom),
						15'($urandom));
		end
	endtask

	task automatic test_noise(input int count);
		int op;
		for (int i = 0; i < count; i++) begin
			op = $urandom_range(0, 9);
			if (op < 4) send_item(OP_WRITE, 14'($urandom), 8'($urandom), 15'($urandom));
			else if (op < 7) read_known();
			else if (op < 9) run_walk(0);
			else send_item(OP_IGNORED, 14'($urandom), 8'($urandom), 15'($urandom));
		end
	endtask

	task automatic test_settings(input int phase);
		case (phase % 5)
			0: begin
				write_reg(CFG_MEM_BASE, '1);
				write_reg(CFG_MEM_SIZE, '1);
			end
			1: begin
				write_reg(CFG_MEM_BASE, '0);
				write_reg(CFG_MEM_SIZE, '0);
			end
			2: begin
				write_reg(CFG_MEM_BASE, 64'h8000_0000_0000_0000);
				write_reg(CFG_MEM_SIZE, 64'd1);
			end
			default: begin
				write_reg(CFG_MEM_BASE, {$urandom, $urandom});
				write_reg(CFG_MEM_SIZE, {$urandom, $urandom});
			end
		endcase
	endtask

	task automatic check_field(input string label, input logic [13:0] expv,
			input logic [13:0] actv);
		if (expv !== actv) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, expv, actv);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		res_t exp_r;
		if (arst_n && results_ch.valid && results_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, actual kind %0h status %0h",
					$time, results_ch.result_kind, results_ch.status);
				mismatches++;
			end else begin
				exp_r = pending_results.pop_front();
				check_field("result_kind", 14'(exp_r.result_kind), 14'(results_ch.result_kind));
				check_field("read_byte", 14'(exp_r.read_byte), 14'(results_ch.read_byte));
				check_field("status", 14'(exp_r.status), 14'(results_ch.status));
				check_field("patch_offset", exp_r.patch_offset, results_ch.patch_offset);
			end
		end
		if (stall_left > 0) begin
			results_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			results_ch.ready <= 1'b1;
			stall_left <= pick_gap();
		end
	end

	always @(posedge clk) begin
		if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int phase;
		clk = 0;
		arst_n = 0;
		items_ch.valid = 0;
		items_ch.opcode = OP_WRITE;
		items_ch.byte_address = 0;
		items_ch.write_byte = 0;
		items_ch.blob_length = 0;
		results_ch.ready = 0;
		cfg_ch.valid = 0;
		cfg_ch.index = CFG_MEM_BASE;
		cfg_ch.data = 0;
		base_reg = 0;
		size_reg = 0;
		stall_left = 0;
		idle_cycles = 0;
		no_idle = 0;
		last_status = ST_NOTFOUND;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		phase = 0;
		while (item_count < 1650) begin
			test_settings(phase);
			no_idle = (phase % 3 == 2);
			test_blob_walks(25);
			phase++;
		end
		no_idle = 0;
		test_noise(150);
		items_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("Covered %0d items and %0d register writes over %0d settings phases.",
			item_count, cfg_count, phase);
		$display("Checked %0d byte reads and %0d walks, %0d of which patched a reg value.",
			read_count, run_count, patched_count);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
